[src/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the directional flux block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define MHDF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition that must never be true at a clock edge outside reset.
`define MHDF_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define MHDF_ASSERT(lbl, prop, msg)
`define MHDF_NEVER(lbl, expr, msg)
`endif
`endif

[src/mhdf_pkg.sv]
// Types, constants and fixed-point helpers of the directional flux block.
package mhdf_pkg;

	localparam int NSTG  = 10;
	localparam int NPROD = 17;

	typedef logic signed [31:0] q_t;
	typedef logic signed [63:0] prod_t;
	typedef logic signed [47:0] wide_t;
	typedef logic signed [34:0] sum_t;

	typedef struct packed {
		logic ov;
		q_t   val;
	} rs_t;

	typedef struct packed {
		logic        func;
		logic [30:0] density;
		q_t          velocity_x;
		q_t          velocity_y;
		q_t          velocity_z;
		q_t          field_x;
		q_t          field_y;
		q_t          field_z;
		logic [30:0] internal_energy;
	} prim_t;

	typedef struct packed {
		q_t   mass_flux;
		q_t   momentum_x_flux;
		q_t   momentum_y_flux;
		q_t   momentum_z_flux;
		q_t   field_x_flux;
		q_t   field_y_flux;
		q_t   field_z_flux;
		q_t   energy_flux;
		logic overflow;
	} flux_t;

	localparam logic       DIR_X     = 1'b0;
	localparam logic [17:0] GAMMA_RST = 18'd109227;
	localparam q_t          ONE_Q     = 32'sd65536;
	localparam prod_t       RND_HALF  = 64'sd32768;
	localparam wide_t       Q_MAX     = 48'sd2147483647;
	localparam wide_t       Q_MIN     = -48'sd2147483648;
	localparam q_t          Q_ZERO    = 32'sd0;

	// Product slots of the first multiplier bank.
	localparam int P_BNBN = 0;
	localparam int P_BTBT = 1;
	localparam int P_BZBZ = 2;
	localparam int P_MASS = 3;
	localparam int P_BNBT = 4;
	localparam int P_BNBZ = 5;
	localparam int P_BTVN = 6;
	localparam int P_BNVT = 7;
	localparam int P_BZVN = 8;
	localparam int P_BNVZ = 9;
	localparam int P_VXVX = 10;
	localparam int P_VYVY = 11;
	localparam int P_VZVZ = 12;
	localparam int P_GM1U = 13;
	localparam int P_GU   = 14;
	localparam int P_BTVT = 15;
	localparam int P_BZVZ = 16;

	function automatic rs_t sat_w(input wide_t x);
		rs_t r;
		if (x > Q_MAX) begin
			r.ov  = 1'b1;
			r.val = Q_MAX[31:0];
		end else if (x < Q_MIN) begin
			r.ov  = 1'b1;
			r.val = Q_MIN[31:0];
		end else begin
			r.ov  = 1'b0;
			r.val = x[31:0];
		end
		return r;
	endfunction

	// Round a Q32.32 product to nearest Q16.16 (ties upward), then saturate.
	function automatic rs_t rnd_sat(input prod_t p);
		prod_t t;
		t = p + RND_HALF;
		return sat_w($signed(t[63:16]));
	endfunction

	// Halving with the same rounding rule: floor((x + 1) / 2).
	function automatic wide_t half_w(input wide_t x);
		wide_t t;
		t = x + 48'sd1;
		return t >>> 1;
	endfunction

endpackage

[src/mhdf_prim_if.sv]
// Channel that carries one cell's primitive state and the flux direction.
interface mhdf_prim_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic        [30:0] density;
	logic signed [31:0] velocity_x;
	logic signed [31:0] velocity_y;
	logic signed [31:0] velocity_z;
	logic signed [31:0] field_x;
	logic signed [31:0] field_y;
	logic signed [31:0] field_z;
	logic        [30:0] internal_energy;

	modport source (
		output valid, func, density, velocity_x, velocity_y, velocity_z,
		       field_x, field_y, field_z, internal_energy,
		input  ready
	);
	modport sink (
		input  valid, func, density, velocity_x, velocity_y, velocity_z,
		       field_x, field_y, field_z, internal_energy,
		output ready
	);
endinterface

[src/mhdf_flux_if.sv]
// Channel that carries the eight flux components and the overflow flag.
interface mhdf_flux_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] mass_flux;
	logic signed [31:0] momentum_x_flux;
	logic signed [31:0] momentum_y_flux;
	logic signed [31:0] momentum_z_flux;
	logic signed [31:0] field_x_flux;
	logic signed [31:0] field_y_flux;
	logic signed [31:0] field_z_flux;
	logic signed [31:0] energy_flux;
	logic               overflow;

	modport source (
		output valid, mass_flux, momentum_x_flux, momentum_y_flux, momentum_z_flux,
		       field_x_flux, field_y_flux, field_z_flux, energy_flux, overflow,
		input  ready
	);
	modport sink (
		input  valid, mass_flux, momentum_x_flux, momentum_y_flux, momentum_z_flux,
		       field_x_flux, field_y_flux, field_z_flux, energy_flux, overflow,
		output ready
	);
endinterface

[src/mhdf_datapath.sv]
// Ten-stage fixed-point datapath that forms the directional MHD fluxes.
module mhdf_datapath
	import mhdf_pkg::*;
(
	input  logic            clk,
	input  logic [NSTG-1:0] en,
	input  logic [17:0]     gamma,
	input  prim_t           prim_d,
	output flux_t           res
);

	// Stage 1: operand capture and direction swap.
	logic func_s1;
	q_t   r_s1, u_s1, g_s1, gm1_s1;
	q_t   vx_s1, vy_s1, vz_s1, bz_s1, vn_s1, vt_s1, bn_s1, bt_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			func_s1 <= prim_d.func;
			r_s1    <= q_t'({1'b0, prim_d.density});
			u_s1    <= q_t'({1'b0, prim_d.internal_energy});
			g_s1    <= q_t'({14'd0, gamma});
			gm1_s1  <= q_t'({14'd0, gamma}) - ONE_Q;
			vx_s1   <= prim_d.velocity_x;
			vy_s1   <= prim_d.velocity_y;
			vz_s1   <= prim_d.velocity_z;
			bz_s1   <= prim_d.field_z;
			if (prim_d.func == DIR_X) begin
				vn_s1 <= prim_d.velocity_x;
				vt_s1 <= prim_d.velocity_y;
				bn_s1 <= prim_d.field_x;
				bt_s1 <= prim_d.field_y;
			end else begin
				vn_s1 <= prim_d.velocity_y;
				vt_s1 <= prim_d.velocity_x;
				bn_s1 <= prim_d.field_y;
				bt_s1 <= prim_d.field_x;
			end
		end
	end

	// Stage 2: first multiplier bank, raw products.
	q_t    opa [NPROD];
	q_t    opb [NPROD];
	prod_t p_s2 [NPROD];
	logic  func_s2;
	q_t    r_s2, vn_s2, vt_s2, vz_s2, bn_s2;

	always_comb begin
		opa[P_BNBN] = bn_s1;  opb[P_BNBN] = bn_s1;
		opa[P_BTBT] = bt_s1;  opb[P_BTBT] = bt_s1;
		opa[P_BZBZ] = bz_s1;  opb[P_BZBZ] = bz_s1;
		opa[P_MASS] = r_s1;   opb[P_MASS] = vn_s1;
		opa[P_BNBT] = bn_s1;  opb[P_BNBT] = bt_s1;
		opa[P_BNBZ] = bn_s1;  opb[P_BNBZ] = bz_s1;
		opa[P_BTVN] = bt_s1;  opb[P_BTVN] = vn_s1;
		opa[P_BNVT] = bn_s1;  opb[P_BNVT] = vt_s1;
		opa[P_BZVN] = bz_s1;  opb[P_BZVN] = vn_s1;
		opa[P_BNVZ] = bn_s1;  opb[P_BNVZ] = vz_s1;
		opa[P_VXVX] = vx_s1;  opb[P_VXVX] = vx_s1;
		opa[P_VYVY] = vy_s1;  opb[P_VYVY] = vy_s1;
		opa[P_VZVZ] = vz_s1;  opb[P_VZVZ] = vz_s1;
		opa[P_GM1U] = gm1_s1; opb[P_GM1U] = u_s1;
		opa[P_GU]   = g_s1;   opb[P_GU]   = u_s1;
		opa[P_BTVT] = bt_s1;  opb[P_BTVT] = vt_s1;
		opa[P_BZVZ] = bz_s1;  opb[P_BZVZ] = vz_s1;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < NPROD; i++) begin
				p_s2[i] <= opa[i] * opb[i];
			end
			func_s2 <= func_s1;
			r_s2    <= r_s1;
			vn_s2   <= vn_s1;
			vt_s2   <= vt_s1;
			vz_s2   <= vz_s1;
			bn_s2   <= bn_s1;
		end
	end

	// Stage 3: round and saturate every product of the first bank.
	rs_t  rs3 [NPROD];
	logic ov3;
	q_t   m_s3 [NPROD];
	logic ov_s3, func_s3;
	q_t   r_s3, vn_s3, vt_s3, vz_s3, bn_s3;

	always_comb begin
		ov3 = 1'b0;
		for (int i = 0; i < NPROD; i++) begin
			rs3[i] = rnd_sat(p_s2[i]);
			ov3    = ov3 | rs3[i].ov;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < NPROD; i++) begin
				m_s3[i] <= rs3[i].val;
			end
			ov_s3   <= ov3;
			func_s3 <= func_s2;
			r_s3    <= r_s2;
			vn_s3   <= vn_s2;
			vt_s3   <= vt_s2;
			vz_s3   <= vz_s2;
			bn_s3   <= bn_s2;
		end
	end

	// Stage 4: first sums, and the products of mass with the velocities.
	rs_t   fldt4, fldz4, vsqh4, cross4;
	logic  func_s4, ov_s4;
	q_t    fldt_s4, fldz_s4, vsqh_s4, cross_s4, mass_s4, bnbt_s4, bnbz_s4, gm1u_s4;
	q_t    r_s4, vn_s4, bn_s4;
	sum_t  hb_s4, ipre_s4;
	prod_t pmvn_s4, pmvt_s4, pmvz_s4;

	always_comb begin
		fldt4  = sat_w(wide_t'(m_s3[P_BTVN]) - wide_t'(m_s3[P_BNVT]));
		fldz4  = sat_w(wide_t'(m_s3[P_BZVN]) - wide_t'(m_s3[P_BNVZ]));
		vsqh4  = sat_w(half_w(wide_t'(m_s3[P_VXVX]) + wide_t'(m_s3[P_VYVY])
		                      + wide_t'(m_s3[P_VZVZ])));
		cross4 = sat_w(wide_t'(m_s3[P_BTVT]) + wide_t'(m_s3[P_BZVZ]));
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			fldt_s4  <= fldt4.val;
			fldz_s4  <= fldz4.val;
			vsqh_s4  <= vsqh4.val;
			cross_s4 <= cross4.val;
			hb_s4    <= sum_t'(half_w(wide_t'(m_s3[P_BTBT]) + wide_t'(m_s3[P_BZBZ])
			                          - wide_t'(m_s3[P_BNBN])));
			ipre_s4  <= sum_t'(wide_t'(m_s3[P_BTBT]) + wide_t'(m_s3[P_BZBZ])
			                   + wide_t'(m_s3[P_GU]));
			mass_s4  <= m_s3[P_MASS];
			bnbt_s4  <= m_s3[P_BNBT];
			bnbz_s4  <= m_s3[P_BNBZ];
			gm1u_s4  <= m_s3[P_GM1U];
			pmvn_s4  <= m_s3[P_MASS] * vn_s3;
			pmvt_s4  <= m_s3[P_MASS] * vt_s3;
			pmvz_s4  <= m_s3[P_MASS] * vz_s3;
			r_s4     <= r_s3;
			vn_s4    <= vn_s3;
			bn_s4    <= bn_s3;
			func_s4  <= func_s3;
			ov_s4    <= ov_s3 | fldt4.ov | fldz4.ov | vsqh4.ov | cross4.ov;
		end
	end

	// Stage 5: round the mass products, multiply density by half the speed squared.
	rs_t   mvn5, mvt5, mvz5;
	logic  func_s5, ov_s5;
	q_t    mvn_s5, mvt_s5, mvz_s5, fldt_s5, fldz_s5, cross_s5, mass_s5;
	q_t    bnbt_s5, bnbz_s5, gm1u_s5, vn_s5, bn_s5;
	sum_t  hb_s5, ipre_s5;
	prod_t pke_s5;

	always_comb begin
		mvn5 = rnd_sat(pmvn_s4);
		mvt5 = rnd_sat(pmvt_s4);
		mvz5 = rnd_sat(pmvz_s4);
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			mvn_s5   <= mvn5.val;
			mvt_s5   <= mvt5.val;
			mvz_s5   <= mvz5.val;
			pke_s5   <= r_s4 * vsqh_s4;
			fldt_s5  <= fldt_s4;
			fldz_s5  <= fldz_s4;
			cross_s5 <= cross_s4;
			mass_s5  <= mass_s4;
			bnbt_s5  <= bnbt_s4;
			bnbz_s5  <= bnbz_s4;
			gm1u_s5  <= gm1u_s4;
			hb_s5    <= hb_s4;
			ipre_s5  <= ipre_s4;
			vn_s5    <= vn_s4;
			bn_s5    <= bn_s4;
			func_s5  <= func_s4;
			ov_s5    <= ov_s4 | mvn5.ov | mvt5.ov | mvz5.ov;
		end
	end

	// Stage 6: momentum fluxes, and the rounded kinetic energy.
	rs_t  momn6, momt6, momz6, ke6;
	logic func_s6, ov_s6;
	q_t   momn_s6, momt_s6, momz_s6, ke_s6, fldt_s6, fldz_s6, cross_s6, mass_s6;
	q_t   vn_s6, bn_s6;
	sum_t ipre_s6;

	always_comb begin
		momn6 = sat_w(wide_t'(mvn_s5) + wide_t'(gm1u_s5) + wide_t'(hb_s5));
		momt6 = sat_w(wide_t'(mvt_s5) - wide_t'(bnbt_s5));
		momz6 = sat_w(wide_t'(mvz_s5) - wide_t'(bnbz_s5));
		ke6   = rnd_sat(pke_s5);
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			momn_s6  <= momn6.val;
			momt_s6  <= momt6.val;
			momz_s6  <= momz6.val;
			ke_s6    <= ke6.val;
			fldt_s6  <= fldt_s5;
			fldz_s6  <= fldz_s5;
			cross_s6 <= cross_s5;
			mass_s6  <= mass_s5;
			ipre_s6  <= ipre_s5;
			vn_s6    <= vn_s5;
			bn_s6    <= bn_s5;
			func_s6  <= func_s5;
			ov_s6    <= ov_s5 | momn6.ov | momt6.ov | momz6.ov | ke6.ov;
		end
	end

	// Stage 7: the energy term that the normal velocity carries.
	rs_t  inner7;
	logic func_s7, ov_s7;
	q_t   inner_s7, momn_s7, momt_s7, momz_s7, fldt_s7, fldz_s7, cross_s7, mass_s7;
	q_t   vn_s7, bn_s7;

	always_comb begin
		inner7 = sat_w(wide_t'(ke_s6) + wide_t'(ipre_s6));
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			inner_s7 <= inner7.val;
			momn_s7  <= momn_s6;
			momt_s7  <= momt_s6;
			momz_s7  <= momz_s6;
			fldt_s7  <= fldt_s6;
			fldz_s7  <= fldz_s6;
			cross_s7 <= cross_s6;
			mass_s7  <= mass_s6;
			vn_s7    <= vn_s6;
			bn_s7    <= bn_s6;
			func_s7  <= func_s6;
			ov_s7    <= ov_s6 | inner7.ov;
		end
	end

	// Stage 8: second multiplier bank for the energy flux.
	logic  func_s8, ov_s8;
	prod_t pe1_s8, pe2_s8;
	q_t    momn_s8, momt_s8, momz_s8, fldt_s8, fldz_s8, mass_s8;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			pe1_s8  <= vn_s7 * inner_s7;
			pe2_s8  <= bn_s7 * cross_s7;
			momn_s8 <= momn_s7;
			momt_s8 <= momt_s7;
			momz_s8 <= momz_s7;
			fldt_s8 <= fldt_s7;
			fldz_s8 <= fldz_s7;
			mass_s8 <= mass_s7;
			func_s8 <= func_s7;
			ov_s8   <= ov_s7;
		end
	end

	// Stage 9: round the energy products.
	rs_t  e1_9, e2_9;
	logic func_s9, ov_s9;
	q_t   e1_s9, e2_s9, momn_s9, momt_s9, momz_s9, fldt_s9, fldz_s9, mass_s9;

	always_comb begin
		e1_9 = rnd_sat(pe1_s8);
		e2_9 = rnd_sat(pe2_s8);
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			e1_s9   <= e1_9.val;
			e2_s9   <= e2_9.val;
			momn_s9 <= momn_s8;
			momt_s9 <= momt_s8;
			momz_s9 <= momz_s8;
			fldt_s9 <= fldt_s8;
			fldz_s9 <= fldz_s8;
			mass_s9 <= mass_s8;
			func_s9 <= func_s8;
			ov_s9   <= ov_s8 | e1_9.ov | e2_9.ov;
		end
	end

	// Stage 10: energy flux and the result register, back in x/y order.
	rs_t   en10;
	flux_t res_s10;

	always_comb begin
		en10 = sat_w(wide_t'(e1_s9) - wide_t'(e2_s9));
	end

	always_ff @(posedge clk) begin
		if (en[9]) begin
			res_s10.mass_flux       <= mass_s9;
			res_s10.momentum_z_flux <= momz_s9;
			res_s10.field_z_flux    <= fldz_s9;
			res_s10.energy_flux     <= en10.val;
			res_s10.overflow        <= ov_s9 | en10.ov;
			if (func_s9 == DIR_X) begin
				res_s10.momentum_x_flux <= momn_s9;
				res_s10.momentum_y_flux <= momt_s9;
				res_s10.field_x_flux    <= Q_ZERO;
				res_s10.field_y_flux    <= fldt_s9;
			end else begin
				res_s10.momentum_x_flux <= momt_s9;
				res_s10.momentum_y_flux <= momn_s9;
				res_s10.field_x_flux    <= fldt_s9;
				res_s10.field_y_flux    <= Q_ZERO;
			end
		end
	end

	assign res = res_s10;

endmodule

[src/mhd_directional_flux.sv]
// Top level of the ideal MHD directional flux block: channels, gamma register, pipeline control.
//
// Each transfer on prim carries one cell's primitive state (density, velocity,
// magnetic field, internal energy, all Q16.16) and a direction bit, 0 for x and
// 1 for y; each transfer on flux returns the eight flux components along that
// direction plus an overflow flag that is set when any product, sum or result
// had to saturate to the signed 32-bit range. The field flux along the chosen
// direction is always zero. The datapath is a ten-stage pipeline: one operand
// capture stage, then the three dependent multiply-and-round passes of the
// energy flux (the squared velocities, density times half the squared speed,
// and normal velocity times the energy sum), each followed by a sum stage;
// each product is registered raw and rounded in the following stage.
// Sustained throughput is one item per clock while the flux receiver is ready.
// Every stage carries its own valid bit and moves forward whenever the stage
// after it is empty or moving, so a stall at the output only holds back input
// once all ten stages are full, and bubbles close up behind a stalled result.
// The adiabatic index is written through cfg_we/cfg_wdata (unsigned Q2.16,
// reset value about 5/3) and should only change while no item is in flight.
`include "assert_macros.svh"

module mhd_directional_flux
	import mhdf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [17:0]        cfg_wdata,
	mhdf_prim_if.sink          prim,
	mhdf_flux_if.source        flux
);

	logic [17:0]     gamma_q;
	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] adv;
	prim_t           prim_d;
	flux_t           res;

	// Adiabatic index register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= GAMMA_RST;
		end else if (cfg_we) begin
			gamma_q <= cfg_wdata;
		end
	end

	// A stage may load when it or any stage after it has room, or when the
	// result register is being drained this cycle.
	always_comb begin
		logic full;
		for (int k = 0; k < NSTG; k++) begin
			full = 1'b1;
			for (int j = 0; j < NSTG; j++) begin
				if (j >= k) begin
					full = full & vld_q[j];
				end
			end
			adv[k] = flux.ready | ~full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= prim.valid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign prim.ready = adv[0];

	always_comb begin
		prim_d.func            = prim.func;
		prim_d.density         = prim.density;
		prim_d.velocity_x      = prim.velocity_x;
		prim_d.velocity_y      = prim.velocity_y;
		prim_d.velocity_z      = prim.velocity_z;
		prim_d.field_x         = prim.field_x;
		prim_d.field_y         = prim.field_y;
		prim_d.field_z         = prim.field_z;
		prim_d.internal_energy = prim.internal_energy;
	end

	mhdf_datapath u_datapath (
		.clk    (clk),
		.en     (adv),
		.gamma  (gamma_q),
		.prim_d (prim_d),
		.res    (res)
	);

	assign flux.valid           = vld_q[NSTG-1];
	assign flux.mass_flux       = res.mass_flux;
	assign flux.momentum_x_flux = res.momentum_x_flux;
	assign flux.momentum_y_flux = res.momentum_y_flux;
	assign flux.momentum_z_flux = res.momentum_z_flux;
	assign flux.field_x_flux    = res.field_x_flux;
	assign flux.field_y_flux    = res.field_y_flux;
	assign flux.field_z_flux    = res.field_z_flux;
	assign flux.energy_flux     = res.energy_flux;
	assign flux.overflow        = res.overflow;

	// The field flux along the chosen direction must be zero in every result.
	`MHDF_ASSERT(a_axis_field_zero, flux.valid |-> (flux.field_x_flux == Q_ZERO || flux.field_y_flux == Q_ZERO), "field flux along the direction is not zero")
	// An accepted transfer must occupy the first stage on the next cycle.
	`MHDF_ASSERT(a_accept_fills_s1, (prim.valid && prim.ready) |=> vld_q[0], "accepted item lost at stage one")
	// An empty first stage always offers ready.
	`MHDF_ASSERT(a_bubble_ready, !vld_q[0] |-> prim.ready, "input blocked although stage one is empty")
	// A full pipeline with a stalled result must not take input.
	`MHDF_NEVER(a_full_stall_blocks, (&vld_q) && !flux.ready && prim.ready, "input taken into a full stalled pipeline")

endmodule

[dv/mhd_directional_flux_test.sv]
// Self-checking testbench of the ideal MHD directional flux block.
`timescale 1ns / 100ps

module mhd_directional_flux_test;
	import mhdf_pkg::*;

	// The direction bit has only the x code in the package; y is its complement.
	localparam logic   DIR_Y        = ~DIR_X;
	localparam longint FLUX_MAX     = 64'sd2147483647;
	localparam longint FLUX_MIN     = -64'sd2147483648;
	localparam int     PHASE_COUNT  = 7;
	localparam int     PHASE_CELLS  = 100;
	localparam int     CALM_CELLS   = 60;
	localparam int     HOLD_CYCLES  = 80;
	localparam int     DRAIN_SLACK  = 20;
	localparam int     LIMIT_CYCLES = 200000;

	// Holds the fluxes predicted for accepted cells, oldest first, and
	// compares every returned result against the front of that queue.
	class flux_scoreboard;
		flux_t       expected_flux[$];
		logic [17:0] gamma_q16;
		int          failures;
		bit          saturated;

		function new();
			gamma_q16 = GAMMA_RST;
			failures  = 0;
		endfunction

		function longint clamp(longint x);
			if (x > FLUX_MAX) begin
				saturated = 1'b1;
				return FLUX_MAX;
			end
			if (x < FLUX_MIN) begin
				saturated = 1'b1;
				return FLUX_MIN;
			end
			return x;
		endfunction

		// Exact product, round to nearest with ties upward, then clamp.
		function longint qmul(longint a, longint b);
			return clamp((a * b + 64'sd32768) >>> 16);
		endfunction

		function longint halve(longint x);
			return (x + 64'sd1) >>> 1;
		endfunction

		function flux_t flux_of(prim_t c);
			longint r, u, g, vx, vy, vz, bx, by, bz, vn, vt, bn, bt;
			longint sbn, sbt, sbz, mass, mom_n, mom_t, mom_z, fld_t, fld_z;
			longint vsq, ke, inner, cross_term, energy;
			bit     ydir;
			flux_t  f;
			saturated = 1'b0;
			ydir = (c.func != DIR_X);
			r  = longint'(c.density);
			u  = longint'(c.internal_energy);
			g  = longint'(gamma_q16);
			vx = longint'(c.velocity_x);
			vy = longint'(c.velocity_y);
			vz = longint'(c.velocity_z);
			bx = longint'(c.field_x);
			by = longint'(c.field_y);
			bz = longint'(c.field_z);
			if (ydir) begin
				vn = vy; vt = vx; bn = by; bt = bx;
			end else begin
				vn = vx; vt = vy; bn = bx; bt = by;
			end
			sbn = qmul(bn, bn);
			sbt = qmul(bt, bt);
			sbz = qmul(bz, bz);
			mass  = qmul(r, vn);
			mom_n = clamp(qmul(mass, vn) + qmul(g - 64'sd65536, u)
				+ halve(sbt + sbz - sbn));
			mom_t = clamp(qmul(mass, vt) - qmul(bn, bt));
			mom_z = clamp(qmul(mass, vz) - qmul(bn, bz));
			fld_t = clamp(qmul(bt, vn) - qmul(bn, vt));
			fld_z = clamp(qmul(bz, vn) - qmul(bn, vz));
			vsq        = qmul(vx, vx) + qmul(vy, vy) + qmul(vz, vz);
			ke         = qmul(r, clamp(halve(vsq)));
			inner      = clamp(ke + sbt + sbz + qmul(g, u));
			cross_term = clamp(qmul(bt, vt) + qmul(bz, vz));
			energy     = clamp(qmul(vn, inner) - qmul(bn, cross_term));
			f.mass_flux       = q_t'(mass);
			f.momentum_x_flux = q_t'(ydir ? mom_t : mom_n);
			f.momentum_y_flux = q_t'(ydir ? mom_n : mom_t);
			f.momentum_z_flux = q_t'(mom_z);
			f.field_x_flux    = ydir ? q_t'(fld_t) : Q_ZERO;
			f.field_y_flux    = ydir ? Q_ZERO : q_t'(fld_t);
			f.field_z_flux    = q_t'(fld_z);
			f.energy_flux     = q_t'(energy);
			f.overflow        = saturated;
			return f;
		endfunction

		function void record_cell(prim_t c);
			expected_flux.push_back(flux_of(c));
		endfunction

		function void match(string name, q_t want, q_t seen);
			if (seen !== want) begin
				$error("%s: expected %0d, got %0d", name, want, seen);
				failures++;
			end
		endfunction

		function void check_flux(flux_t got);
			flux_t want;
			if (expected_flux.size() == 0) begin
				$error("flux transfer with no cell outstanding");
				failures++;
				return;
			end
			want = expected_flux.pop_front();
			match("mass_flux", want.mass_flux, got.mass_flux);
			match("momentum_x_flux", want.momentum_x_flux, got.momentum_x_flux);
			match("momentum_y_flux", want.momentum_y_flux, got.momentum_y_flux);
			match("momentum_z_flux", want.momentum_z_flux, got.momentum_z_flux);
			match("field_x_flux", want.field_x_flux, got.field_x_flux);
			match("field_y_flux", want.field_y_flux, got.field_y_flux);
			match("field_z_flux", want.field_z_flux, got.field_z_flux);
			match("energy_flux", want.energy_flux, got.energy_flux);
			match("overflow", q_t'(want.overflow), q_t'(got.overflow));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [17:0] cfg_wdata;

	mhdf_prim_if prim_ch ();
	mhdf_flux_if flux_ch ();

	flux_scoreboard sb;

	// Set by the stimulus to ask the receiver for one long hold-off.
	bit hold_request = 1'b0;
	// Set for the closing stretch, where neither side inserts idle cycles.
	bit calm = 1'b0;
	int cycle_count = 0;

	mhd_directional_flux u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.prim      (prim_ch),
		.flux      (flux_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Every flux transfer is checked at the edge where it takes place; the
	// values read here are the ones that stood before the edge.
	always @(posedge clk) begin : watch_flux
		flux_t got;
		if (arst_n === 1'b1 && flux_ch.valid === 1'b1 && flux_ch.ready === 1'b1) begin
			got.mass_flux       = flux_ch.mass_flux;
			got.momentum_x_flux = flux_ch.momentum_x_flux;
			got.momentum_y_flux = flux_ch.momentum_y_flux;
			got.momentum_z_flux = flux_ch.momentum_z_flux;
			got.field_x_flux    = flux_ch.field_x_flux;
			got.field_y_flux    = flux_ch.field_y_flux;
			got.field_z_flux    = flux_ch.field_z_flux;
			got.energy_flux     = flux_ch.energy_flux;
			got.overflow        = flux_ch.overflow;
			sb.check_flux(got);
		end
	end

	// Receiver. It mixes runs of ready with random stall bursts.
	// On request it holds off for a long stretch, long enough for the ten
	// pipeline stages to fill and the block to drop ready on its input.
	initial begin : receiver
		flux_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				flux_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (calm) begin
				flux_ch.ready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				flux_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				flux_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// Offers one cell and returns at the edge of its transfer. Valid is left
	// high so that a following cell goes out back to back; the cell is noted
	// in the scoreboard at once, so the queue never lags the channel.
	task automatic send_cell(prim_t c);
		prim_ch.valid           <= 1'b1;
		prim_ch.func            <= c.func;
		prim_ch.density         <= c.density;
		prim_ch.velocity_x      <= c.velocity_x;
		prim_ch.velocity_y      <= c.velocity_y;
		prim_ch.velocity_z      <= c.velocity_z;
		prim_ch.field_x         <= c.field_x;
		prim_ch.field_y         <= c.field_y;
		prim_ch.field_z         <= c.field_z;
		prim_ch.internal_energy <= c.internal_energy;
		do @(posedge clk); while (prim_ch.ready !== 1'b1);
		sb.record_cell(c);
	endtask

	task automatic idle_sender(int cycles);
		prim_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// The sender stops until every outstanding flux has come back. Each cell
	// yields exactly one result, so an empty queue means an empty pipeline.
	task automatic drain();
		prim_ch.valid <= 1'b0;
		while (sb.expected_flux.size() != 0) @(posedge clk);
	endtask

	// Gamma only changes with nothing in flight.
	task automatic write_gamma(logic [17:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.gamma_q16 = value;
	endtask

	function automatic prim_t make_cell(logic dir, logic [30:0] r, q_t vx, q_t vy, q_t vz,
			q_t bx, q_t by, q_t bz, logic [30:0] u);
		prim_t c;
		c.func            = dir;
		c.density         = r;
		c.velocity_x      = vx;
		c.velocity_y      = vy;
		c.velocity_z      = vz;
		c.field_x         = bx;
		c.field_y         = by;
		c.field_z         = bz;
		c.internal_energy = u;
		return c;
	endfunction

	// Signed fields: extremes and zero now and then, full-range noise, and
	// mostly values within +/-16.0 so that many results stay unsaturated.
	function automatic q_t rand_signed();
		case ($urandom_range(0, 11))
			0: begin
				return q_t'(32'h8000_0000);
			end
			1: begin
				return q_t'(32'h7FFF_FFFF);
			end
			2: begin
				return Q_ZERO;
			end
			3, 4: begin
				return q_t'($urandom);
			end
			default: begin
				return q_t'($urandom_range(0, 2097152)) - 32'sd1048576;
			end
		endcase
	endfunction

	function automatic logic [30:0] rand_unsigned();
		logic [31:0] raw;
		case ($urandom_range(0, 11))
			0: begin
				return 31'd0;
			end
			1: begin
				return 31'h7FFF_FFFF;
			end
			2, 3: begin
				raw = $urandom;
				return raw[30:0];
			end
			default: begin
				raw = $urandom_range(0, 1048576);
				return raw[30:0];
			end
		endcase
	endfunction

	function automatic prim_t random_cell();
		return make_cell($urandom_range(0, 1) == 1 ? DIR_Y : DIR_X, rand_unsigned(),
			rand_signed(), rand_signed(), rand_signed(),
			rand_signed(), rand_signed(), rand_signed(), rand_unsigned());
	endfunction

	// Directed cells, run with gamma at its reset value.
	task automatic run_directed();
		localparam q_t QMAX = q_t'(32'h7FFF_FFFF);
		localparam q_t QMIN = q_t'(32'h8000_0000);
		localparam logic [30:0] UMAX = 31'h7FFF_FFFF;
		// An empty cell in both directions.
		send_cell(make_cell(DIR_X, 0, 0, 0, 0, 0, 0, 0, 0));
		send_cell(make_cell(DIR_Y, 0, 0, 0, 0, 0, 0, 0, 0));
		// An ordinary cell seen along x and along y: the field flux along the
		// chosen direction must come out zero in both.
		send_cell(make_cell(DIR_X, 65536, 32768, -16384, 8192, 49152, -98304, 131072, 98304));
		send_cell(make_cell(DIR_Y, 65536, 32768, -16384, 8192, 49152, -98304, 131072, 98304));
		// Every field at its largest value, then signed fields at their most
		// negative, in each direction; these saturate nearly everywhere.
		send_cell(make_cell(DIR_X, UMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, UMAX));
		send_cell(make_cell(DIR_Y, UMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, UMAX));
		send_cell(make_cell(DIR_X, UMAX, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, UMAX));
		send_cell(make_cell(DIR_Y, 0, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, 0));
		// Products that land exactly on a half unit, positive and negative,
		// to pin down rounding of ties upward.
		send_cell(make_cell(DIR_X, 32768, 1, 0, 0, 0, 0, 0, 0));
		send_cell(make_cell(DIR_X, 32768, -1, 0, 0, 0, 0, 0, 0));
		send_cell(make_cell(DIR_Y, 98304, 3, -3, 1, 1, -1, 3, 1));
		// Pure field along the direction: momentum flux is minus half of it
		// squared, an odd value tests the halving.
		send_cell(make_cell(DIR_X, 0, 0, 0, 0, 196611, 0, 0, 0));
		send_cell(make_cell(DIR_Y, 0, 0, 0, 0, 0, -196611, 0, 0));
		// Pressure alone, at the largest internal energy.
		send_cell(make_cell(DIR_X, 0, 0, 0, 0, 0, 0, 0, UMAX));
		// Largest density with a slow normal velocity.
		send_cell(make_cell(DIR_Y, UMAX, -70000, 1, 0, 0, 0, 0, 65536));
		// Opposite field extremes across the plane.
		send_cell(make_cell(DIR_Y, 131072, 65536, -65536, 32768, QMAX, QMIN, QMAX, 65536));
		send_cell(make_cell(DIR_X, 131072, -65536, 65536, -32768, QMIN, QMAX, QMIN, 65536));
		// Fast flow where the kinetic energy sum saturates but the mass
		// flux does not.
		send_cell(make_cell(DIR_X, 1, 65536, QMAX, QMIN, 0, 0, 0, 0));
	endtask

	// Main stimulus: directed cells, then seven phases of random cells, one
	// per gamma setting. The settings include both limits of the legal range
	// and the two ends of the register itself.
	initial begin : stimulus
		logic [17:0] gamma_plan [PHASE_COUNT];
		sb = new();
		gamma_plan[0] = GAMMA_RST;
		gamma_plan[1] = 18'd65536;
		gamma_plan[2] = 18'd196608;
		gamma_plan[3] = 18'd0;
		gamma_plan[4] = 18'h3FFFF;
		gamma_plan[5] = 18'($urandom_range(65536, 196608));
		gamma_plan[6] = GAMMA_RST;

		arst_n                  <= 1'b0;
		cfg_we                  <= 1'b0;
		cfg_wdata               <= '0;
		prim_ch.valid           <= 1'b0;
		prim_ch.func            <= DIR_X;
		prim_ch.density         <= '0;
		prim_ch.velocity_x      <= '0;
		prim_ch.velocity_y      <= '0;
		prim_ch.velocity_z      <= '0;
		prim_ch.field_x         <= '0;
		prim_ch.field_y         <= '0;
		prim_ch.field_z         <= '0;
		prim_ch.internal_energy <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		for (int p = 0; p < PHASE_COUNT; p++) begin
			// Phase zero keeps the reset gamma; the others write a new one
			// once the pipeline is empty.
			if (p > 0) begin
				drain();
				write_gamma(gamma_plan[p]);
			end
			// In the third phase the receiver stalls long while cells keep
			// coming, so the input side has to back up.
			if (p == 2) begin
				hold_request = 1'b1;
			end
			for (int n = 0; n < PHASE_CELLS; n++) begin
				if (p == PHASE_COUNT - 1 && n == PHASE_CELLS - CALM_CELLS) begin
					calm = 1'b1;
				end
				if (!calm && $urandom_range(0, 4) == 0) begin
					idle_sender($urandom_range(1, 13));
				end
				send_cell(random_cell());
			end
		end

		// Wait for the last fluxes, then give a stray result time to show.
		drain();
		repeat (DRAIN_SLACK) @(posedge clk);
		if (sb.failures == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/mhdf_pkg.sv
src/mhdf_prim_if.sv
src/mhdf_flux_if.sv
src/mhdf_datapath.sv
src/mhd_directional_flux.sv
dv/mhd_directional_flux_test.sv
